FILE: hw/rtl/rppls_pkg.sv
package rppls_pkg;

  typedef enum logic [2:0] {
    ST_INIT        = 3'd0,
    ST_M_SEND      = 3'd1,
    ST_M_SEND_DONE = 3'd2,
    ST_M_RX        = 3'd3,
    ST_S_RX        = 3'd4,
    ST_S_SEND      = 3'd5,
    ST_S_SEND_DONE = 3'd6,
    ST_ERROR       = 3'd7
  } proto_state_t;

  typedef logic [5:0] cmd_t;

  localparam cmd_t CMD_NONE  = 6'b000000;
  localparam cmd_t CMD_CFG   = 6'b000001;
  localparam cmd_t CMD_TX    = 6'b000010;
  localparam cmd_t CMD_RX    = 6'b000100;
  localparam cmd_t CMD_STBY  = 6'b001000;
  localparam cmd_t CMD_CLR   = 6'b010000;
  localparam cmd_t CMD_RSTAT = 6'b100000;

  localparam int FLAG_TX  = 0;
  localparam int FLAG_RX  = 1;
  localparam int FLAG_TO  = 2;
  localparam int FLAG_CRC = 3;

  localparam logic [1:0] CLS_PING = 2'd0;
  localparam logic [1:0] CLS_PONG = 2'd1;
  localparam logic [1:0] CLS_NONE = 2'd2;

  localparam logic [1:0] PT_LORA = 2'd0;
  localparam logic [1:0] PT_GFSK = 2'd1;

  localparam logic ACT_STEP = 1'b0;
  localparam logic ACT_STOP = 1'b1;

  localparam logic ROLE_MASTER = 1'b0;
  localparam logic ROLE_SLAVE  = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_ERROR = 1'b1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PACKET_TYPE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PING_PERIOD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PONG_DELAY  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RX_GUARD    = 2'd3;

  localparam logic [1:0]  RST_PACKET_TYPE = PT_LORA;
  localparam logic [15:0] RST_PING_PERIOD = 16'd1000;
  localparam logic [15:0] RST_PONG_DELAY  = 16'd400;
  localparam logic [7:0]  RST_RX_GUARD    = 8'd5;

  typedef struct packed {
    logic              action;
    logic [31:0]       now_ms;
    logic              irq_raised;
    logic [3:0]        irq_flags;
    logic [31:0]       irq_instant_ms;
    logic [1:0]        payload_class;
    logic signed [7:0] rx_rssi;
  } in_item_t;

  typedef struct packed {
    cmd_t              command_flags;
    logic              node_role;
    logic              link_status;
    logic              state_changed;
    logic [31:0]       tx_count;
    logic [31:0]       rx_good_count;
    logic [31:0]       rx_bad_count;
    logic [31:0]       rx_timeout_count;
    logic signed [7:0] recent_rssi;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  packet_type;
    logic [15:0] ping_period_ms;
    logic [15:0] pong_delay_ms;
    logic [7:0]  rx_guard_ms;
  } cfg_regs_t;

endpackage

FILE: hw/rtl/rppls_in_if.sv
interface rppls_in_if import rppls_pkg::*;;
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/rppls_out_if.sv
interface rppls_out_if import rppls_pkg::*;;
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/rppls_cfg_if.sv
interface rppls_cfg_if import rppls_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/radio_ping_pong_link_sequencer.sv
// Ping-pong link sequencer for a master/slave radio link. Each input transfer is one
// runtime step; each step yields exactly one result transfer with the radio command
// bits, the role, the link status and the four wrapping statistics counters. A step
// is registered at the input, evaluated against the protocol state and written to
// the result register, so the block takes one step per clock cycle unless the result
// channel stalls. Configuration registers are written through the cfg channel, which
// is always ready; the user must write them only while no step is in flight, which
// the block does not enforce. TIME_WIDTH sets the width of the stored instants and
// of the wrapping time differences; COUNT_WIDTH sets the counter width.
module radio_ping_pong_link_sequencer import rppls_pkg::*; #(
  parameter int TIME_WIDTH  = 32,
  parameter int COUNT_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  rppls_in_if.sink   in_ch,
  rppls_out_if.source out_ch,
  rppls_cfg_if.sink  cfg_ch
);

  cfg_regs_t cfg_r;
  logic      step_valid;
  in_item_t  step_item;
  logic      take;
  out_item_t step_result;
  logic      out_valid_r;
  logic      out_valid_nxt;
  out_item_t out_item_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.packet_type    <= RST_PACKET_TYPE;
      cfg_r.ping_period_ms <= RST_PING_PERIOD;
      cfg_r.pong_delay_ms  <= RST_PONG_DELAY;
      cfg_r.rx_guard_ms    <= RST_RX_GUARD;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        REG_PACKET_TYPE: cfg_r.packet_type    <= cfg_ch.data[1:0];
        REG_PING_PERIOD: cfg_r.ping_period_ms <= cfg_ch.data;
        REG_PONG_DELAY:  cfg_r.pong_delay_ms  <= cfg_ch.data;
        REG_RX_GUARD:    cfg_r.rx_guard_ms    <= cfg_ch.data[7:0];
      endcase
    end
  end

  rppls_in_reg u_in_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .take    (take),
    .valid_o (step_valid),
    .item_o  (step_item)
  );

  assign take = step_valid && (!out_valid_r || out_ch.ready);

  rppls_core #(
    .TIME_WIDTH  (TIME_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (take),
    .item    (step_item),
    .cfg     (cfg_r),
    .result  (step_result)
  );

  assign out_valid_nxt = take || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_item_r <= step_result;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_item_r;

endmodule

FILE: hw/rtl/rppls_in_reg.sv
module rppls_in_reg import rppls_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  rppls_in_if.sink       in_ch,
  input  logic           take,
  output logic           valid_o,
  output in_item_t       item_o
);

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;

  assign in_ch.ready = !valid_r || take;
  assign valid_nxt   = in_ch.valid || (valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r <= in_ch.data;
    end
  end

  assign valid_o = valid_r;
  assign item_o  = item_r;

endmodule

FILE: hw/rtl/rppls_core.sv
module rppls_core import rppls_pkg::*; #(
  parameter int TIME_WIDTH  = 32,
  parameter int COUNT_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step_en,
  input  in_item_t  item,
  input  cfg_regs_t cfg,
  output out_item_t result
);

  localparam int CW = (TIME_WIDTH > 17) ? TIME_WIDTH : 17;

  proto_state_t st_r, st_nxt;
  logic role_r, role_nxt;
  logic status_r, status_nxt;
  logic [TIME_WIDTH-1:0] ltx_r, ltx_nxt;
  logic [TIME_WIDTH-1:0] lrx_r, lrx_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r [4];
  logic [COUNT_WIDTH-1:0] cnt_nxt [4];
  logic signed [7:0] rssi_r, rssi_nxt;

  logic       clr_cnt;
  logic       inc_tx, inc_good, inc_bad;
  logic [1:0] inc_to;
  cmd_t       cmd;

  logic irq, f_tx, f_rx, f_to, f_crc;
  logic fetch_go;
  logic [1:0] fetch_cls;
  logic signed [7:0] fetch_rssi;
  logic is_ping, is_pong;
  logic [TIME_WIDTH-1:0] now_t, inst_t, lrx_s, d_tx, d_rx, d_rx_s;
  logic [15:0] rxlim;
  logic tx_late, rx_late, s_late, pong_due;

  assign irq   = item.irq_raised;
  assign f_tx  = item.irq_flags[FLAG_TX];
  assign f_rx  = item.irq_flags[FLAG_RX];
  assign f_to  = item.irq_flags[FLAG_TO];
  assign f_crc = item.irq_flags[FLAG_CRC];

  assign fetch_go = irq && !f_crc && f_rx;

  always_comb begin
    if (cfg.packet_type > PT_GFSK) begin
      fetch_cls  = CLS_NONE;
      fetch_rssi = '0;
    end else begin
      fetch_cls  = (item.payload_class <= CLS_PONG) ? item.payload_class : CLS_NONE;
      fetch_rssi = item.rx_rssi;
    end
  end

  assign is_ping = fetch_go && (fetch_cls == CLS_PING);
  assign is_pong = fetch_go && (fetch_cls == CLS_PONG);

  assign now_t  = TIME_WIDTH'(item.now_ms);
  assign inst_t = TIME_WIDTH'(item.irq_instant_ms);
  assign lrx_s  = is_ping ? inst_t : lrx_r;
  assign d_tx   = now_t - ltx_r;
  assign d_rx   = now_t - lrx_r;
  assign d_rx_s = now_t - lrx_s;

  assign rxlim = (cfg.ping_period_ms > 16'(cfg.rx_guard_ms)) ?
                 cfg.ping_period_ms - 16'(cfg.rx_guard_ms) : 16'd0;

  assign tx_late  = CW'(d_tx) > CW'(cfg.ping_period_ms);
  assign rx_late  = CW'(d_tx) > CW'(rxlim);
  assign s_late   = CW'(d_rx_s) > CW'({rxlim, 1'b0});
  assign pong_due = CW'(d_rx) > CW'(cfg.pong_delay_ms);

  always_comb begin
    st_nxt     = st_r;
    role_nxt   = role_r;
    status_nxt = status_r;
    ltx_nxt    = ltx_r;
    lrx_nxt    = lrx_r;
    rssi_nxt   = rssi_r;
    clr_cnt    = 1'b0;
    inc_tx     = 1'b0;
    inc_good   = 1'b0;
    inc_bad    = 1'b0;
    inc_to     = 2'd0;
    if (item.action == ACT_STOP) begin
      st_nxt  = ST_INIT;
      clr_cnt = 1'b1;
    end else begin
      unique case (st_r)
        ST_INIT: begin
          status_nxt = STATUS_OK;
          if (cfg.packet_type <= PT_GFSK) begin
            ltx_nxt = now_t;
            st_nxt  = ST_M_SEND;
          end else begin
            st_nxt = ST_ERROR;
          end
        end
        ST_M_SEND: begin
          if (tx_late) begin
            st_nxt = ST_M_SEND_DONE;
          end
        end
        ST_M_SEND_DONE: begin
          if (irq && f_tx) begin
            inc_tx  = 1'b1;
            ltx_nxt = inst_t;
            st_nxt  = ST_M_RX;
          end
        end
        ST_M_RX: begin
          if (irq) begin
            if (f_crc) begin
              inc_bad = 1'b1;
            end else if (f_rx) begin
              rssi_nxt = fetch_rssi;
              if (is_pong) begin
                inc_good = 1'b1;
                st_nxt   = ST_M_SEND;
              end else if (is_ping) begin
                lrx_nxt  = ltx_r;
                role_nxt = ROLE_SLAVE;
                st_nxt   = ST_S_SEND;
              end else begin
                inc_bad = 1'b1;
                st_nxt  = ST_M_SEND;
              end
            end
            if (f_to) begin
              st_nxt = ST_M_SEND;
              inc_to = inc_to + 2'd1;
            end
          end else if (rx_late) begin
            st_nxt = ST_M_SEND;
            inc_to = inc_to + 2'd1;
          end
        end
        ST_S_RX: begin
          if (irq) begin
            if (f_crc) begin
              inc_bad = 1'b1;
            end else if (f_rx) begin
              rssi_nxt = fetch_rssi;
              if (is_ping) begin
                lrx_nxt  = inst_t;
                inc_good = 1'b1;
                st_nxt   = ST_S_SEND;
              end else if (is_pong) begin
                ltx_nxt  = inst_t;
                role_nxt = ROLE_MASTER;
                st_nxt   = ST_M_SEND;
              end else begin
                inc_bad = 1'b1;
              end
            end
            if (f_to) begin
              ltx_nxt  = inst_t;
              role_nxt = ROLE_MASTER;
              st_nxt   = ST_M_SEND;
              inc_to   = inc_to + 2'd1;
            end
          end
          if (s_late) begin
            ltx_nxt  = inst_t;
            role_nxt = ROLE_MASTER;
            st_nxt   = ST_M_SEND;
            inc_to   = inc_to + 2'd1;
          end
        end
        ST_S_SEND: begin
          if (pong_due) begin
            st_nxt = ST_S_SEND_DONE;
          end
        end
        ST_S_SEND_DONE: begin
          if (irq && f_tx) begin
            inc_tx = 1'b1;
            st_nxt = ST_S_RX;
          end
        end
        ST_ERROR: begin
          status_nxt = STATUS_ERROR;
        end
      endcase
    end
  end

  always_comb begin
    cmd = CMD_NONE;
    if (item.action == ACT_STOP) begin
      cmd = CMD_STBY;
    end else begin
      unique case (st_r)
        ST_INIT: begin
          cmd = CMD_CFG | CMD_RSTAT;
        end
        ST_M_SEND: begin
          if (tx_late) begin
            cmd = CMD_TX;
          end
        end
        ST_M_SEND_DONE: begin
          if (irq) begin
            cmd = f_tx ? (CMD_CLR | CMD_RX) : CMD_CLR;
          end
        end
        ST_M_RX: begin
          if (irq) begin
            cmd = CMD_CLR;
          end else if (rx_late) begin
            cmd = CMD_STBY;
          end
        end
        ST_S_RX: begin
          cmd = (irq ? CMD_CLR : CMD_NONE) | (s_late ? CMD_STBY : CMD_NONE);
        end
        ST_S_SEND: begin
          if (pong_due) begin
            cmd = CMD_TX;
          end
        end
        ST_S_SEND_DONE: begin
          if (irq && f_tx) begin
            cmd = CMD_CLR | CMD_RX;
          end
        end
        ST_ERROR: begin
          cmd = CMD_NONE;
        end
      endcase
    end
  end

  always_comb begin
    if (clr_cnt) begin
      cnt_nxt[0] = '0;
      cnt_nxt[1] = '0;
      cnt_nxt[2] = '0;
      cnt_nxt[3] = '0;
    end else begin
      cnt_nxt[0] = cnt_r[0] + COUNT_WIDTH'(inc_tx);
      cnt_nxt[1] = cnt_r[1] + COUNT_WIDTH'(inc_good);
      cnt_nxt[2] = cnt_r[2] + COUNT_WIDTH'(inc_bad);
      cnt_nxt[3] = cnt_r[3] + COUNT_WIDTH'(inc_to);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_INIT;
      role_r   <= ROLE_MASTER;
      status_r <= STATUS_OK;
      ltx_r    <= '0;
      lrx_r    <= '0;
      cnt_r[0] <= '0;
      cnt_r[1] <= '0;
      cnt_r[2] <= '0;
      cnt_r[3] <= '0;
      rssi_r   <= '0;
    end else if (step_en) begin
      st_r     <= st_nxt;
      role_r   <= role_nxt;
      status_r <= status_nxt;
      ltx_r    <= ltx_nxt;
      lrx_r    <= lrx_nxt;
      cnt_r[0] <= cnt_nxt[0];
      cnt_r[1] <= cnt_nxt[1];
      cnt_r[2] <= cnt_nxt[2];
      cnt_r[3] <= cnt_nxt[3];
      rssi_r   <= rssi_nxt;
    end
  end

  always_comb begin
    result.command_flags    = cmd;
    result.node_role        = role_nxt;
    result.link_status      = status_nxt;
    result.state_changed    = (st_nxt != st_r);
    result.tx_count         = 32'(cnt_nxt[0]);
    result.rx_good_count    = 32'(cnt_nxt[1]);
    result.rx_bad_count     = 32'(cnt_nxt[2]);
    result.rx_timeout_count = 32'(cnt_nxt[3]);
    result.recent_rssi      = rssi_nxt;
  end

endmodule

FILE: sim/rppls_link_checker.sv
module rppls_link_checker import rppls_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  rppls_in_if         in_mon,
  rppls_out_if        out_mon,
  rppls_cfg_if        cfg_mon,
  output int unsigned pending,
  output int unsigned checked,
  output int unsigned fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TALLY_TX      = 0;
  localparam int TALLY_GOOD    = 1;
  localparam int TALLY_BAD     = 2;
  localparam int TALLY_TIMEOUT = 3;

  cfg_regs_t         regs;
  proto_state_t      link_state;
  logic              role_q;
  logic              status_q;
  logic [31:0]       sent_at;
  logic [31:0]       heard_at;
  logic [31:0]       tally [4];
  logic signed [7:0] last_level;
  out_item_t         awaited_reports [$];

  task automatic report(string note);
    $display("[%0t] mismatch: %s", $realtime, note);
    fail_count++;
  endtask

  task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report($sformatf("result %0d %s is %0h, expected %0h", checked, name, got, want));
    end
  endtask

  function automatic void count_up(int which);
    tally[which] = tally[which] + 32'd1;
  endfunction

  function automatic logic [1:0] fetch_frame(logic [1:0] cls, logic signed [7:0] level);
    if (regs.packet_type > PT_GFSK) begin
      last_level = '0;
      return CLS_NONE;
    end
    last_level = level;
    return (cls <= CLS_PONG) ? cls : CLS_NONE;
  endfunction

  function automatic out_item_t advance_link(in_item_t s);
    proto_state_t was;
    cmd_t         cmd;
    logic [1:0]   kind;
    logic [15:0]  rx_limit;
    logic [16:0]  slave_limit;
    out_item_t    r;
    was = link_state;
    cmd = CMD_NONE;
    rx_limit = (regs.ping_period_ms > 16'(regs.rx_guard_ms)) ?
               regs.ping_period_ms - 16'(regs.rx_guard_ms) : 16'd0;
    slave_limit = {rx_limit, 1'b0};
    if (s.action == ACT_STOP) begin
      cmd = CMD_STBY;
      for (int k = 0; k < 4; k++) tally[k] = '0;
      link_state = ST_INIT;
    end else begin
      case (link_state)
        ST_INIT: begin
          status_q = STATUS_OK;
          cmd = CMD_CFG | CMD_RSTAT;
          if (regs.packet_type <= PT_GFSK) begin
            sent_at = s.now_ms;
            link_state = ST_M_SEND;
          end else begin
            link_state = ST_ERROR;
          end
        end
        ST_M_SEND: begin
          if (32'(s.now_ms - sent_at) > 32'(regs.ping_period_ms)) begin
            cmd = CMD_TX;
            link_state = ST_M_SEND_DONE;
          end
        end
        ST_M_SEND_DONE: begin
          if (s.irq_raised) begin
            if (s.irq_flags[FLAG_TX]) begin
              count_up(TALLY_TX);
              sent_at = s.irq_instant_ms;
              cmd |= CMD_RX;
              link_state = ST_M_RX;
            end
            cmd |= CMD_CLR;
          end
        end
        ST_M_RX: begin
          if (s.irq_raised) begin
            if (s.irq_flags[FLAG_CRC]) begin
              count_up(TALLY_BAD);
            end else if (s.irq_flags[FLAG_RX]) begin
              kind = fetch_frame(s.payload_class, s.rx_rssi);
              if (kind == CLS_PONG) begin
                count_up(TALLY_GOOD);
                link_state = ST_M_SEND;
              end else if (kind == CLS_PING) begin
                heard_at = sent_at;
                role_q = ROLE_SLAVE;
                link_state = ST_S_SEND;
              end else begin
                link_state = ST_M_SEND;
                count_up(TALLY_BAD);
              end
            end
            if (s.irq_flags[FLAG_TO]) begin
              link_state = ST_M_SEND;
              count_up(TALLY_TIMEOUT);
            end
            cmd |= CMD_CLR;
          end else if (32'(s.now_ms - sent_at) > 32'(rx_limit)) begin
            cmd |= CMD_STBY;
            link_state = ST_M_SEND;
            count_up(TALLY_TIMEOUT);
          end
        end
        ST_S_RX: begin
          if (s.irq_raised) begin
            if (s.irq_flags[FLAG_CRC]) begin
              count_up(TALLY_BAD);
            end else if (s.irq_flags[FLAG_RX]) begin
              kind = fetch_frame(s.payload_class, s.rx_rssi);
              if (kind == CLS_PING) begin
                heard_at = s.irq_instant_ms;
                count_up(TALLY_GOOD);
                link_state = ST_S_SEND;
              end else if (kind == CLS_PONG) begin
                sent_at = s.irq_instant_ms;
                role_q = ROLE_MASTER;
                link_state = ST_M_SEND;
              end else begin
                count_up(TALLY_BAD);
              end
            end
            if (s.irq_flags[FLAG_TO]) begin
              sent_at = s.irq_instant_ms;
              role_q = ROLE_MASTER;
              link_state = ST_M_SEND;
              count_up(TALLY_TIMEOUT);
            end
            cmd |= CMD_CLR;
          end
          if (32'(s.now_ms - heard_at) > 32'(slave_limit)) begin
            sent_at = s.irq_instant_ms;
            role_q = ROLE_MASTER;
            link_state = ST_M_SEND;
            cmd |= CMD_STBY;
            count_up(TALLY_TIMEOUT);
          end
        end
        ST_S_SEND: begin
          if (32'(s.now_ms - heard_at) > 32'(regs.pong_delay_ms)) begin
            cmd = CMD_TX;
            link_state = ST_S_SEND_DONE;
          end
        end
        ST_S_SEND_DONE: begin
          if (s.irq_raised && s.irq_flags[FLAG_TX]) begin
            cmd = CMD_CLR | CMD_RX;
            count_up(TALLY_TX);
            link_state = ST_S_RX;
          end
        end
        default: begin
          status_q = STATUS_ERROR;
        end
      endcase
    end
    r.command_flags    = cmd;
    r.node_role        = role_q;
    r.link_status      = status_q;
    r.state_changed    = (link_state != was);
    r.tx_count         = tally[TALLY_TX];
    r.rx_good_count    = tally[TALLY_GOOD];
    r.rx_bad_count     = tally[TALLY_BAD];
    r.rx_timeout_count = tally[TALLY_TIMEOUT];
    r.recent_rssi      = last_level;
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t got;
    out_item_t want;
    if (!rst_n) begin
      regs.packet_type    = RST_PACKET_TYPE;
      regs.ping_period_ms = RST_PING_PERIOD;
      regs.pong_delay_ms  = RST_PONG_DELAY;
      regs.rx_guard_ms    = RST_RX_GUARD;
      link_state = ST_INIT;
      role_q     = ROLE_MASTER;
      status_q   = STATUS_OK;
      sent_at    = '0;
      heard_at   = '0;
      last_level = '0;
      for (int k = 0; k < 4; k++) tally[k] = '0;
      awaited_reports.delete();
      pending <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.data;
        if (awaited_reports.size() == 0) begin
          report($sformatf("result with command_flags %0h arrived with none awaited",
                           got.command_flags));
        end else begin
          want = awaited_reports.pop_front();
          compare_field("command_flags", 32'(got.command_flags),
                        32'(want.command_flags));
          compare_field("node_role", 32'(got.node_role), 32'(want.node_role));
          compare_field("link_status", 32'(got.link_status), 32'(want.link_status));
          compare_field("state_changed", 32'(got.state_changed),
                        32'(want.state_changed));
          compare_field("tx_count", got.tx_count, want.tx_count);
          compare_field("rx_good_count", got.rx_good_count, want.rx_good_count);
          compare_field("rx_bad_count", got.rx_bad_count, want.rx_bad_count);
          compare_field("rx_timeout_count", got.rx_timeout_count, want.rx_timeout_count);
          compare_field("recent_rssi", 32'(got.recent_rssi), 32'(want.recent_rssi));
        end
        checked++;
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_PACKET_TYPE: regs.packet_type    = cfg_mon.data[1:0];
          REG_PING_PERIOD: regs.ping_period_ms = cfg_mon.data;
          REG_PONG_DELAY:  regs.pong_delay_ms  = cfg_mon.data;
          REG_RX_GUARD:    regs.rx_guard_ms    = cfg_mon.data[7:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        awaited_reports.push_back(advance_link(in_mon.data));
      end
      pending <= awaited_reports.size();
    end
  end
endmodule

FILE: sim/testbench.sv
module testbench import rppls_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        sink_ready = 1'b0;
  bit          calm = 1'b0;
  logic [31:0] clock_ms = '0;
  int unsigned steps_sent = 0;
  int unsigned settings_used = 0;
  int unsigned pending;
  int unsigned checked;
  int unsigned fail_count;

  rppls_in_if  in_ch();
  rppls_out_if out_ch();
  rppls_cfg_if cfg_ch();

  radio_ping_pong_link_sequencer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  rppls_link_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_mon    (cfg_ch),
    .pending    (pending),
    .checked    (checked),
    .fail_count (fail_count)
  );

  always #10 clk = ~clk;

  assign out_ch.ready = sink_ready;

  always @(posedge clk) begin
    sink_ready <= calm || ($urandom_range(0, 99) >= 34);
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic in_item_t step_of(logic act, logic [31:0] now, logic irq,
                                       logic [3:0] flags, logic [31:0] inst,
                                       logic [1:0] cls, logic [7:0] level);
    in_item_t s;
    s.action         = act;
    s.now_ms         = now;
    s.irq_raised     = irq;
    s.irq_flags      = flags;
    s.irq_instant_ms = inst;
    s.payload_class  = cls;
    s.rx_rssi        = level;
    return s;
  endfunction

  function automatic in_item_t make_step(int unsigned span);
    in_item_t    s;
    int unsigned pick;
    if ($urandom_range(0, 99) < 3) begin
      clock_ms = $urandom;
    end else begin
      clock_ms = clock_ms + $urandom_range(0, span);
    end
    s.action     = ($urandom_range(0, 99) < 2) ? ACT_STOP : ACT_STEP;
    s.now_ms     = clock_ms;
    s.irq_raised = ($urandom_range(0, 99) < 55);
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1, 2: s.irq_flags = 4'(1 << FLAG_TX);
      3, 4, 5: s.irq_flags = 4'(1 << FLAG_RX);
      6:       s.irq_flags = 4'(1 << FLAG_TO);
      7:       s.irq_flags = 4'((1 << FLAG_CRC) | (1 << FLAG_RX));
      default: s.irq_flags = 4'($urandom);
    endcase
    s.irq_instant_ms = ($urandom_range(0, 4) == 0) ? $urandom
                                                   : clock_ms - $urandom_range(0, span);
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      s.payload_class = CLS_PING;
    end else if (pick < 85) begin
      s.payload_class = CLS_PONG;
    end else begin
      s.payload_class = 2'($urandom_range(2, 3));
    end
    s.rx_rssi = 8'($urandom);
    return s;
  endfunction

  task automatic push_step(in_item_t s);
    while (!calm && $urandom_range(0, 99) < 34) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    steps_sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic load_regs(cfg_regs_t regs);
    put_reg(REG_PACKET_TYPE, CFG_DATA_W'(regs.packet_type));
    put_reg(REG_PING_PERIOD, regs.ping_period_ms);
    put_reg(REG_PONG_DELAY, regs.pong_delay_ms);
    put_reg(REG_RX_GUARD, CFG_DATA_W'(regs.rx_guard_ms));
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  task automatic run_phase(logic [1:0] ptype, logic [15:0] period, logic [15:0] delay,
                           logic [7:0] guard, int unsigned span, int count, bit quiet);
    cfg_regs_t regs;
    in_item_t  s;
    regs.packet_type    = ptype;
    regs.ping_period_ms = period;
    regs.pong_delay_ms  = delay;
    regs.rx_guard_ms    = guard;
    load_regs(regs);
    calm <= quiet;
    for (int n = 0; n < count; n++) begin
      s = make_step(span);
      if (n == count / 3 && ptype > PT_GFSK) s.action = ACT_STOP;
      push_step(s);
      if ($urandom_range(0, 59) == 0) drain();
    end
    drain();
    calm <= 1'b0;
  endtask

  initial begin
    in_item_t directed [$];
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    directed = '{
      step_of(ACT_STEP, 32'd0, 1'b0, 4'(0), 32'd0, CLS_NONE, 8'd0),
      step_of(ACT_STEP, 32'd1000, 1'b0, 4'(0), 32'd0, CLS_NONE, 8'd0),
      step_of(ACT_STEP, 32'd1001, 1'b0, 4'(0), 32'd0, CLS_NONE, 8'd0),
      step_of(ACT_STEP, 32'd1002, 1'b1, 4'(0), 32'd1002, CLS_NONE, 8'd0),
      step_of(ACT_STEP, 32'd1003, 1'b1, 4'(1 << FLAG_TX), 32'd1003, CLS_NONE, 8'd0),
      step_of(ACT_STEP, 32'd1100, 1'b1, 4'((1 << FLAG_CRC) | (1 << FLAG_RX)), 32'd1100,
              CLS_PONG, 8'd10),
      step_of(ACT_STEP, 32'd1150, 1'b1, 4'(1 << FLAG_RX), 32'd1150, 2'd3, 8'h80),
      step_of(ACT_STEP, 32'd2154, 1'b0, 4'(0), 32'd0, CLS_NONE, 8'd0),
      step_of(ACT_STEP, 32'd2160, 1'b1, 4'(1 << FLAG_TX), 32'd2160, CLS_NONE, 8'd0),
      step_of(ACT_STEP, 32'd2200, 1'b1, 4'(1 << FLAG_RX), 32'd2200, CLS_PONG, 8'h80),
      step_of(ACT_STEP, 32'd3161, 1'b0, 4'(0), 32'd0, CLS_NONE, 8'd0),
      step_of(ACT_STEP, 32'd3170, 1'b1, 4'(1 << FLAG_TX), 32'd3170, CLS_NONE, 8'd0),
      step_of(ACT_STEP, 32'd4166, 1'b0, 4'(0), 32'd0, CLS_NONE, 8'd0),
      step_of(ACT_STEP, 32'd4171, 1'b0, 4'(0), 32'd0, CLS_NONE, 8'd0),
      step_of(ACT_STEP, 32'd4172, 1'b1, 4'(1 << FLAG_TX), 32'd4172, CLS_NONE, 8'd0),
      step_of(ACT_STEP, 32'd4180, 1'b1, 4'(1 << FLAG_RX), 32'd4180, CLS_PING, 8'h7F),
      step_of(ACT_STEP, 32'd4573, 1'b0, 4'(0), 32'd0, CLS_NONE, 8'd0),
      step_of(ACT_STEP, 32'd4580, 1'b1, 4'hF, 32'd4580, CLS_PING, 8'd0),
      step_of(ACT_STEP, 32'd4600, 1'b1, 4'(1 << FLAG_RX), 32'd4600, CLS_PING, 8'd5),
      step_of(ACT_STEP, 32'd5001, 1'b0, 4'(0), 32'd0, CLS_NONE, 8'd0),
      step_of(ACT_STEP, 32'd5002, 1'b1, 4'(1 << FLAG_TX), 32'd5002, CLS_NONE, 8'd0),
      step_of(ACT_STEP, 32'd6591, 1'b1, 4'(1 << FLAG_TO), 32'd6590, CLS_NONE, 8'd0),
      step_of(ACT_STEP, 32'hFFFF_FFFF, 1'b1, 4'hF, 32'hFFFF_FFFF, 2'd3, 8'hFF),
      step_of(ACT_STOP, 32'hFFFF_FFFF, 1'b1, 4'hF, 32'hFFFF_FFFF, 2'd3, 8'hFF),
      step_of(ACT_STEP, 32'd0, 1'b0, 4'(0), 32'd0, CLS_NONE, 8'd0)
    };
    foreach (directed[i]) push_step(directed[i]);
    drain();

    clock_ms = 32'd7000;
    run_phase(PT_GFSK, 16'd40, 16'd15, 8'd3, 12, 150, 1'b1);
    run_phase(PT_LORA, 16'd0, 16'd0, 8'd0, 3, 100, 1'b0);
    run_phase(2'd2, 16'd30, 16'd10, 8'd255, 10, 60, 1'b0);
    run_phase(2'd3, 16'hFFFF, 16'hFFFF, 8'd255, 20000, 60, 1'b0);
    clock_ms = 32'hFFFF_0000;
    run_phase(PT_GFSK, 16'hFFFF, 16'hFFFF, 8'd0, 30000, 80, 1'b0);
    run_phase(PT_LORA, 16'd25, 16'd8, 8'd5, 9, 150, 1'b0);

    $display("Sent %0d steps under %0d register settings, with stops, error starts,",
             steps_sent, settings_used);
    $display("wrapped time and idle gaps on both channels; %0d results compared.", checked);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

FILE: files.f
hw/rtl/rppls_pkg.sv
hw/rtl/rppls_in_if.sv
hw/rtl/rppls_out_if.sv
hw/rtl/rppls_cfg_if.sv
hw/rtl/rppls_in_reg.sv
hw/rtl/rppls_core.sv
hw/rtl/radio_ping_pong_link_sequencer.sv
sim/rppls_link_checker.sv
sim/testbench.sv
